// ----- rtl/ttce_pkg.sv -----
// Shared constants, codes and control structs of the text terminal cell engine.
// Used by ttce_ctrl, ttce_datapath and text_terminal_cell_engine_core; no dependencies.
package ttce_pkg;

   localparam int MAX_COLUMNS_DEF = 128;
   localparam int MAX_LINES_DEF   = 32;

   localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
   localparam logic [2:0] OP_PUT_AT     = 3'd1;
   localparam logic [2:0] OP_SET_CURSOR = 3'd2;
   localparam logic [2:0] OP_READ_CELL  = 3'd3;
   localparam logic [2:0] OP_CLEAR      = 3'd4;
   localparam logic [2:0] OP_RECOLOR    = 3'd5;

   localparam logic [1:0] CSR_NUM_COLS     = 2'd0;
   localparam logic [1:0] CSR_NUM_ROWS     = 2'd1;
   localparam logic [1:0] CSR_DEFAULT_ATTR = 2'd2;

   localparam logic [7:0] CH_NEWLINE     = 8'd10;
   localparam logic [7:0] CH_BACKSPACE   = 8'd8;
   localparam logic [7:0] CH_SPACE       = 8'd32;
   localparam logic [7:0] FALLBACK_ATTR  = 8'h0F;
   localparam logic [7:0] RESET_ATTR     = 8'h0F;
   localparam logic [7:0] RESET_NUM_COLS = 8'd80;
   localparam logic [5:0] RESET_NUM_ROWS = 6'd25;

   localparam logic [1:0] SCAN_INIT    = 2'd0;
   localparam logic [1:0] SCAN_CLEAR   = 2'd1;
   localparam logic [1:0] SCAN_SCROLL  = 2'd2;
   localparam logic [1:0] SCAN_RECOLOR = 2'd3;

   typedef struct packed {
      logic       load;
      logic       exec;
      logic       step;
      logic [1:0] scan_mode;
      logic       respond;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic need_scroll;
      logic is_read;
      logic is_clear;
      logic is_recolor;
   } dp_status_type;

endpackage

// ----- rtl/ttce_ctrl.sv -----
// Sequencer of the text terminal cell engine: issues load, execute, sweep and respond commands.
// Depends on ttce_pkg for the command and status structs.
module ttce_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  ttce_pkg::dp_status_type  status,
   output ttce_pkg::dp_cmd_type     cmd,
   output logic                     busy
);
   import ttce_pkg::*;

   localparam logic [2:0] ST_INIT    = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_EXEC    = 3'd2;
   localparam logic [2:0] ST_SCROLL  = 3'd3;
   localparam logic [2:0] ST_RECOLOR = 3'd4;
   localparam logic [2:0] ST_CLEAR   = 3'd5;
   localparam logic [2:0] ST_DONE    = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            cmd.step      = 1'b1;
            cmd.scan_mode = SCAN_INIT;
            if (status.scan_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.need_scroll)     state_in = ST_SCROLL;
            else if (status.is_recolor) state_in = ST_RECOLOR;
            else if (status.is_clear)   state_in = ST_CLEAR;
            else if (status.is_read)    state_in = ST_DONE;
            else begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_SCROLL: begin
            cmd.step      = 1'b1;
            cmd.scan_mode = SCAN_SCROLL;
            if (status.scan_last) state_in = ST_DONE;
         end
         ST_RECOLOR: begin
            cmd.step      = 1'b1;
            cmd.scan_mode = SCAN_RECOLOR;
            if (status.scan_last) state_in = ST_DONE;
         end
         ST_CLEAR: begin
            cmd.step      = 1'b1;
            cmd.scan_mode = SCAN_CLEAR;
            if (status.scan_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_INIT;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- rtl/ttce_datapath.sv -----
// Datapath of the text terminal cell engine: registers, cursor logic, cell stores and sweeps.
// Depends on ttce_pkg; driven by ttce_ctrl through dp_cmd_type.
module ttce_datapath #(
   parameter int MAX_COLUMNS = ttce_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_LINES   = ttce_pkg::MAX_LINES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ttce_pkg::dp_cmd_type     cmd,
   output ttce_pkg::dp_status_type  status,
   input  logic [2:0]               req_operation,
   input  logic [7:0]               req_ch,
   input  logic [6:0]               req_col_in,
   input  logic [4:0]               req_row_in,
   input  logic [7:0]               req_attr_in,
   input  logic [7:0]               req_match_attr,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [7:0]               csr_wdata,
   output logic                     rsp_valid,
   output logic [6:0]               rsp_cell_col,
   output logic [4:0]               rsp_cell_row,
   output logic [7:0]               rsp_cell_char,
   output logic [7:0]               rsp_cell_attr,
   output logic                     rsp_cell_valid,
   output logic                     rsp_scrolled,
   output logic [6:0]               rsp_cursor_col,
   output logic [4:0]               rsp_cursor_row
);
   import ttce_pkg::*;

   localparam int DEPTH = MAX_COLUMNS * MAX_LINES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SCW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int SRW   = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int LIMC  = (MAX_COLUMNS < 128) ? MAX_COLUMNS : 128;
   localparam int LIMR  = (MAX_LINES < 32) ? MAX_LINES : 32;

   localparam logic [1:0] PM_COPY    = 2'd0;
   localparam logic [1:0] PM_FILL    = 2'd1;
   localparam logic [1:0] PM_RECOLOR = 2'd2;

   function automatic logic [AW-1:0] cell_addr(input logic [SCW-1:0] c,
                                               input logic [SRW:0]   r);
      cell_addr = AW'(AW'(r) * AW'(MAX_COLUMNS)) + AW'(c);
   endfunction

   // Configuration registers.
   logic [7:0] cols_ff;
   logic [5:0] rows_ff;
   logic [7:0] dattr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= RESET_NUM_COLS;
         rows_ff  <= RESET_NUM_ROWS;
         dattr_ff <= RESET_ATTR;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_COLS:     cols_ff  <= csr_wdata;
            CSR_NUM_ROWS:     rows_ff  <= csr_wdata[5:0];
            CSR_DEFAULT_ATTR: dattr_ff <= csr_wdata;
            default:          ;
         endcase
      end
   end

   logic [6:0] last_col;
   logic [4:0] last_row;
   always_comb begin
      if (cols_ff == 8'd0)               last_col = 7'd0;
      else if (cols_ff > 8'(LIMC))       last_col = 7'(LIMC - 1);
      else                               last_col = 7'(cols_ff - 8'd1);
      if (rows_ff == 6'd0)               last_row = 5'd0;
      else if (rows_ff > 6'(LIMR))       last_row = 5'(LIMR - 1);
      else                               last_row = 5'(rows_ff - 6'd1);
   end

   // Captured request word.
   logic [2:0] op_ff;
   logic [7:0] ch_ff, ai_ff, ma_ff;
   logic [6:0] ci_ff;
   logic [4:0] ri_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_operation;
         ch_ff <= req_ch;
         ci_ff <= req_col_in;
         ri_ff <= req_row_in;
         ai_ff <= req_attr_in;
         ma_ff <= req_match_attr;
      end
   end

   logic [6:0] cur_col_ff;
   logic [4:0] cur_row_ff;

   // Clamped cursor and coordinates.
   logic [6:0] cc, ci;
   logic [4:0] cr, ri;
   assign cc = (cur_col_ff > last_col) ? last_col : cur_col_ff;
   assign cr = (cur_row_ff > last_row) ? last_row : cur_row_ff;
   assign ci = (ci_ff > last_col) ? last_col : ci_ff;
   assign ri = (ri_ff > last_row) ? last_row : ri_ff;

   // Streamed character: target cell and cursor movement.
   logic       pc_write, overflow;
   logic [6:0] wc, nxt_col;
   logic [4:0] wr;
   logic [5:0] nxt_row;
   logic [7:0] wch;
   always_comb begin
      pc_write = 1'b0;
      wc       = cc;
      wr       = cr;
      wch      = ch_ff;
      nxt_col  = cc;
      nxt_row  = {1'b0, cr};
      if (ch_ff == CH_NEWLINE) begin
         nxt_col = 7'd0;
         nxt_row = {1'b0, cr} + 6'd1;
      end else if (ch_ff == CH_BACKSPACE) begin
         pc_write = 1'b1;
         wch      = CH_SPACE;
         if (cc != 7'd0) begin
            wc = cc - 7'd1;
         end else if (cr != 5'd0) begin
            wc = last_col;
            wr = cr - 5'd1;
         end
         nxt_col = wc;
         nxt_row = {1'b0, wr};
      end else begin
         pc_write = 1'b1;
         if (cc == last_col) begin
            nxt_col = 7'd0;
            nxt_row = {1'b0, cr} + 6'd1;
         end else begin
            nxt_col = cc + 7'd1;
         end
      end
   end
   assign overflow = (nxt_row > {1'b0, last_row});

   // Sweep counters.
   logic [SCW-1:0] scol_ff, scan_lc;
   logic [SRW-1:0] srow_ff, scan_lr;
   logic           scan_last;
   always_comb begin
      if (cmd.scan_mode == SCAN_INIT || cmd.scan_mode == SCAN_CLEAR) begin
         scan_lc = SCW'(MAX_COLUMNS - 1);
         scan_lr = SRW'(MAX_LINES - 1);
      end else begin
         scan_lc = SCW'(last_col);
         scan_lr = SRW'(last_row);
      end
   end
   assign scan_last = (scol_ff == scan_lc) && (srow_ff == scan_lr);

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         scol_ff <= '0;
         srow_ff <= '0;
      end else if (cmd.step) begin
         if (scol_ff == scan_lc) begin
            scol_ff <= '0;
            srow_ff <= srow_ff + 1'b1;
         end else begin
            scol_ff <= scol_ff + 1'b1;
         end
      end
   end

   // A sweep writes in the cycle after it reads, through this pending stage.
   logic          pend_valid_ff;
   logic [AW-1:0] pend_addr_ff;
   logic [1:0]    pend_mode_ff;
   logic [7:0]    pend_attr_ff;
   always_ff @(posedge clock) begin
      if (reset) pend_valid_ff <= 1'b0;
      else       pend_valid_ff <= cmd.step;
   end
   always_ff @(posedge clock) begin
      pend_addr_ff <= cell_addr(scol_ff, {1'b0, srow_ff});
      pend_attr_ff <= (cmd.scan_mode == SCAN_INIT) ? RESET_ATTR : dattr_ff;
      case (cmd.scan_mode)
         SCAN_SCROLL:  pend_mode_ff <= (srow_ff == scan_lr) ? PM_FILL : PM_COPY;
         SCAN_RECOLOR: pend_mode_ff <= PM_RECOLOR;
         default:      pend_mode_ff <= PM_FILL;
      endcase
   end

   // Cell stores.
   logic [7:0] char_mem [DEPTH];
   logic [7:0] attr_mem [DEPTH];
   logic [7:0] rd_char_ff, rd_attr_ff, recolor_attr;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          we_char, we_attr;
   logic [7:0]    wr_char, wr_attr;

   assign recolor_attr = (dattr_ff != 8'd0) ? dattr_ff : FALLBACK_ATTR;

   always_comb begin
      if (cmd.exec)
         rd_addr = cell_addr(SCW'(ci), {1'b0, SRW'(ri)});
      else if (cmd.scan_mode == SCAN_SCROLL)
         rd_addr = cell_addr(scol_ff, {1'b0, srow_ff} + 1'b1);
      else
         rd_addr = cell_addr(scol_ff, {1'b0, srow_ff});
   end

   always_comb begin
      we_char = 1'b0;
      we_attr = 1'b0;
      wr_addr = pend_addr_ff;
      wr_char = CH_SPACE;
      wr_attr = pend_attr_ff;
      if (cmd.exec && op_ff == OP_PUT_CHAR && pc_write) begin
         we_char = 1'b1;
         we_attr = 1'b1;
         wr_addr = cell_addr(SCW'(wc), {1'b0, SRW'(wr)});
         wr_char = wch;
         wr_attr = dattr_ff;
      end else if (cmd.exec && op_ff == OP_PUT_AT) begin
         we_char = 1'b1;
         we_attr = 1'b1;
         wr_addr = cell_addr(SCW'(ci), {1'b0, SRW'(ri)});
         wr_char = ch_ff;
         wr_attr = ai_ff;
      end else if (pend_valid_ff) begin
         case (pend_mode_ff)
            PM_COPY: begin
               we_char = 1'b1;
               we_attr = 1'b1;
               wr_char = rd_char_ff;
               wr_attr = rd_attr_ff;
            end
            PM_RECOLOR: begin
               we_attr = (rd_attr_ff == ma_ff);
               wr_attr = recolor_attr;
            end
            default: begin
               we_char = 1'b1;
               we_attr = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we_char) char_mem[wr_addr] <= wr_char;
      if (we_attr) attr_mem[wr_addr] <= wr_attr;
      rd_char_ff <= char_mem[rd_addr];
      rd_attr_ff <= attr_mem[rd_addr];
   end

   // Result of the executed word.
   logic [6:0] res_col, ncur_col;
   logic [4:0] res_row, ncur_row;
   logic [7:0] res_char, res_attr;
   logic       res_valid, res_scr;
   always_comb begin
      res_col   = 7'd0;
      res_row   = 5'd0;
      res_char  = 8'd0;
      res_attr  = 8'd0;
      res_valid = 1'b0;
      res_scr   = 1'b0;
      ncur_col  = cc;
      ncur_row  = cr;
      case (op_ff)
         OP_PUT_CHAR: begin
            if (pc_write) begin
               res_col   = wc;
               res_row   = wr;
               res_char  = wch;
               res_attr  = dattr_ff;
               res_valid = 1'b1;
            end
            ncur_col = nxt_col;
            ncur_row = overflow ? last_row : nxt_row[4:0];
            res_scr  = overflow;
         end
         OP_PUT_AT: begin
            res_col   = ci;
            res_row   = ri;
            res_char  = ch_ff;
            res_attr  = ai_ff;
            res_valid = 1'b1;
         end
         OP_SET_CURSOR: begin
            ncur_col = ci;
            ncur_row = ri;
         end
         OP_READ_CELL: begin
            res_col   = ci;
            res_row   = ri;
            res_valid = 1'b1;
         end
         OP_CLEAR: begin
            ncur_col = 7'd0;
            ncur_row = 5'd0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff <= 7'd0;
         cur_row_ff <= 5'd0;
         rsp_valid  <= 1'b0;
      end else begin
         rsp_valid <= cmd.respond;
         if (cmd.exec) begin
            cur_col_ff <= ncur_col;
            cur_row_ff <= ncur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_cell_col   <= res_col;
         rsp_cell_row   <= res_row;
         rsp_cell_char  <= res_char;
         rsp_cell_attr  <= res_attr;
         rsp_cell_valid <= res_valid;
         rsp_scrolled   <= res_scr;
         rsp_cursor_col <= ncur_col;
         rsp_cursor_row <= ncur_row;
      end else if (cmd.respond && op_ff == OP_READ_CELL) begin
         rsp_cell_char <= rd_char_ff;
         rsp_cell_attr <= rd_attr_ff;
      end
   end

   assign status.scan_last   = scan_last;
   assign status.need_scroll = (op_ff == OP_PUT_CHAR) && overflow;
   assign status.is_read     = (op_ff == OP_READ_CELL);
   assign status.is_clear    = (op_ff == OP_CLEAR);
   assign status.is_recolor  = (op_ff == OP_RECOLOR);

endmodule

// ----- rtl/text_terminal_cell_engine_core.sv -----
// Top level of the text terminal cell engine: controller plus datapath.
// Depends on ttce_pkg, ttce_ctrl and ttce_datapath.
//
//   Channel   Ports                       Handshake
//   request   start, busy, req_*          taken when start is high and busy is low
//   response  rsp_valid, rsp_*            one-cycle strobe, cannot be held off
//   config    csr_we, csr_index, csr_wdata written on any edge with csr_we high
//
// A word is captured, then executed, and then sweeps the stores if it needs to.
// A scroll walks the active area once, one cell per cycle through the single
// store write port. Recolor likewise walks the active area, and clear walks
// the whole store. A read passes through a done state because the store read
// data is registered. After reset the block fills the whole store with spaces
// and attribute 0x0F, with busy high; configuration writes are taken meanwhile.
// Responses are never stalled: each appears for exactly one cycle.
module text_terminal_cell_engine_core #(
   parameter int MAX_COLUMNS = ttce_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_LINES   = ttce_pkg::MAX_LINES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_operation,
   input  logic [7:0] req_ch,
   input  logic [6:0] req_col_in,
   input  logic [4:0] req_row_in,
   input  logic [7:0] req_attr_in,
   input  logic [7:0] req_match_attr,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output logic       rsp_valid,
   output logic [6:0] rsp_cell_col,
   output logic [4:0] rsp_cell_row,
   output logic [7:0] rsp_cell_char,
   output logic [7:0] rsp_cell_attr,
   output logic       rsp_cell_valid,
   output logic       rsp_scrolled,
   output logic [6:0] rsp_cursor_col,
   output logic [4:0] rsp_cursor_row
);
   import ttce_pkg::*;

   // The controller only sequences; every register holding word data or
   // terminal state lives in the datapath.
   dp_cmd_type    cmd;
   dp_status_type status;

   ttce_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   ttce_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_LINES   (MAX_LINES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_operation  (req_operation),
      .req_ch         (req_ch),
      .req_col_in     (req_col_in),
      .req_row_in     (req_row_in),
      .req_attr_in    (req_attr_in),
      .req_match_attr (req_match_attr),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_cell_col   (rsp_cell_col),
      .rsp_cell_row   (rsp_cell_row),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr),
      .rsp_cell_valid (rsp_cell_valid),
      .rsp_scrolled   (rsp_scrolled),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row)
   );

   // An accepted word always moves the block out of idle for its execute cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not make the block busy");

   // At most one response per word: strobes are never back to back.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   // A response without a cell reports a zero character and attribute.
   a_no_cell_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_cell_valid |-> rsp_cell_char == 8'd0 && rsp_cell_attr == 8'd0)
      else $error("cell fields not cleared on a response without a cell");

endmodule
